>>> rtl/core/iob_pkg.sv
// ----------------------------------------------------------------------------
// iob_pkg: shared types and constants of the insulin bolus advisor
// Holds the item structs, the action codes, the register indexes and the
// default sizes of the delivery table.
// ----------------------------------------------------------------------------
package iob_pkg;

	localparam int TableDepthDef  = 64;
	localparam int TickMinutesDef = 5;
	localparam int TimeBitsDef    = 20;

	localparam int AmtW    = 20;
	localparam int HoursW  = 4;
	localparam int DivNumW = 32;
	localparam int DivDenW = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;

	localparam logic [AmtW-1:0] AMT_MAX      = 20'hFFFFF;
	localparam logic [9:0]      MILLI        = 10'd1000;
	localparam logic [9:0]      MIN_PER_HOUR = 10'd60;
	localparam logic [6:0]      PCT_FULL     = 7'd100;

	// action codes
	localparam logic [2:0] ACT_BOLUS     = 3'd0;
	localparam logic [2:0] ACT_BASAL     = 3'd1;
	localparam logic [2:0] ACT_SUGGEST   = 3'd2;
	localparam logic [2:0] ACT_EXT_START = 3'd3;
	localparam logic [2:0] ACT_EXT_TICK  = 3'd4;
	localparam logic [2:0] ACT_LOAD_GLU  = 3'd5;

	// extended bolus phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_IMMED  = 2'd1;
	localparam logic [1:0] PH_SPREAD = 2'd2;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_CARB_RATIO  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CORR_FACTOR = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TARGET_GLU  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ACTION_HRS  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BASAL_AMT   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_EXT_TOTAL   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_IMMED_PCT   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_EXT_HOURS   = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [19:0] now_minutes;
		logic [14:0] dose_amount;
		logic [8:0]  carbs_grams;
		logic [9:0]  glucose_reading;
	} req_item_t;

	typedef struct packed {
		logic [15:0] suggested_bolus;
		logic [19:0] insulin_on_board;
		logic [9:0]  glucose_estimate;
		logic [15:0] delivered_now;
		logic [1:0]  extended_phase_out;
		logic        table_overflow;
	} rsp_item_t;

endpackage

>>> rtl/core/insulin_bolus_advisor_iob.sv
// ----------------------------------------------------------------------------
// insulin_bolus_advisor_iob: bolus advisor with linear insulin-on-board table
// per item: every live table entry costs one ram read, one multiply and a
//   radix-16 divide, free or expired entries cost only the read; one item
//   is worked at a time
// throughput: the shared iterative divider and the single ram read port bound it
// reset: arst_n clears control state, then a clearing pass marks every table
//   entry free before the first item is taken
// ----------------------------------------------------------------------------
module insulin_bolus_advisor_iob #(
	parameter int TABLE_DEPTH  = iob_pkg::TableDepthDef,
	parameter int TICK_MINUTES = iob_pkg::TickMinutesDef,
	parameter int TIME_BITS    = iob_pkg::TimeBitsDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  iob_pkg::req_item_t               req_item,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output iob_pkg::rsp_item_t               rsp_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [iob_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [iob_pkg::CfgDatW-1:0]      cfg_data
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int WORD_W = 1 + iob_pkg::HoursW + iob_pkg::AmtW + TIME_BITS;
	localparam int SUM_W  = iob_pkg::AmtW + IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// sequencer states
	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_PRE  = 5'd2;
	localparam logic [4:0] ST_DIV  = 5'd3;
	localparam logic [4:0] ST_SUG1 = 5'd4;
	localparam logic [4:0] ST_SUG2 = 5'd5;
	localparam logic [4:0] ST_IMM  = 5'd6;
	localparam logic [4:0] ST_HR1  = 5'd7;
	localparam logic [4:0] ST_HR2  = 5'd8;
	localparam logic [4:0] ST_REC  = 5'd9;
	localparam logic [4:0] ST_RD   = 5'd10;
	localparam logic [4:0] ST_EV   = 5'd11;
	localparam logic [4:0] ST_MUL  = 5'd12;
	localparam logic [4:0] ST_ACC  = 5'd13;
	localparam logic [4:0] ST_FIN  = 5'd14;
	localparam logic [4:0] ST_GLU  = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;

	// configuration registers
	logic [7:0]  carb_ratio_q;
	logic [8:0]  corr_factor_q;
	logic [8:0]  target_glu_q;
	logic [3:0]  action_hrs_q;
	logic [15:0] basal_amt_q;
	logic [14:0] ext_total_q;
	logic [6:0]  immed_pct_q;
	logic [3:0]  ext_hours_q;

	// block state
	logic [9:0]  glu_q;
	logic [19:0] on_board_q;
	logic [1:0]  phase_q;
	logic [5:0]  tick_q;
	logic [3:0]  hrs_done_q;

	// sequencer and per-item registers
	logic [4:0]             st_q;
	logic [4:0]             ret_q;
	iob_pkg::req_item_t     item_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [15:0]            amt_q;
	logic                   lower_q;
	logic                   scan_only_q;
	logic                   match_q;
	logic [IDX_W-1:0]       match_idx_q;
	logic [19:0]            match_amt_q;
	logic [3:0]             match_hrs_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [19:0]            e_amt_q;
	logic [9:0]             left_q;
	logic [9:0]             span_q;
	logic [18:0]            food_q;
	logic [19:0]            corr_q;
	logic                   corr_neg_q;
	logic [15:0]            delivered_q;
	logic                   ovf_q;
	logic [15:0]            sugg_q;
	logic                   rsp_valid_q;
	iob_pkg::rsp_item_t     rsp_q;

	// shared divider: quotient shifts into div_num_q, 4 bits a cycle
	logic [iob_pkg::DivNumW-1:0] div_num_q;
	logic [iob_pkg::DivDenW-1:0] div_den_q;
	logic [iob_pkg::DivDenW-1:0] div_rem_q;
	logic [2:0]                  div_cnt_q;
	logic [iob_pkg::DivNumW-1:0] div_num_d;
	logic [iob_pkg::DivDenW-1:0] div_rem_d;
	logic [iob_pkg::DivDenW:0]   div_sh;

	// table ram
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// entry fields as read
	logic                 e_valid;
	logic [3:0]           e_hours;
	logic [19:0]          e_amt;
	logic [TIME_BITS-1:0] e_time;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] dt;
	logic [9:0]           e_span;
	logic                 e_dead;

	// clamped settings
	logic [6:0]  pct;
	logic [3:0]  ehr;
	logic [7:0]  ratio;
	logic [8:0]  cf;
	logic [6:0]  tick_sum;
	logic [3:0]  hrs_next;

	// finish arithmetic
	logic [20:0]        merge_sum;
	logic [19:0]        merge_amt;
	logic [SUM_W-1:0]   sum_fin;
	logic [19:0]        sum_sat;
	logic signed [23:0] sugg_total;

	assign req_ready = (st_q == ST_IDLE);
	// registers change only between items
	assign cfg_ready = (st_q == ST_IDLE) && !req_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	assign pct   = (immed_pct_q > iob_pkg::PCT_FULL) ? iob_pkg::PCT_FULL : immed_pct_q;
	assign ehr   = (ext_hours_q == 4'd0) ? 4'd1 : ext_hours_q;
	assign ratio = (carb_ratio_q == 8'd0) ? 8'd1 : carb_ratio_q;
	assign cf    = (corr_factor_q == 9'd0) ? 9'd1 : corr_factor_q;
	assign tick_sum = 7'(tick_q) + 7'(TICK_MINUTES);
	assign hrs_next = hrs_done_q + 4'd1;

	// decode the entry just read
	assign e_valid = ram_rdata[WORD_W-1];
	assign e_hours = ram_rdata[WORD_W-2 -: iob_pkg::HoursW];
	assign e_amt   = ram_rdata[TIME_BITS +: iob_pkg::AmtW];
	assign e_time  = ram_rdata[TIME_BITS-1:0];
	assign now_t   = TIME_BITS'(item_q.now_minutes);
	assign dt      = now_t - e_time;
	assign e_span  = 10'(e_hours * iob_pkg::MIN_PER_HOUR);
	assign e_dead  = (e_amt == 20'd0) || (dt >= TIME_BITS'(e_span));

	// finish of a record: merge saturates at full scale
	assign merge_sum = 21'(match_amt_q) + 21'(amt_q);
	assign merge_amt = merge_sum[20] ? iob_pkg::AMT_MAX : merge_sum[19:0];

	always_comb begin
		sum_fin = sum_q;
		if (!scan_only_q) begin
			if (match_q) begin
				sum_fin = sum_q - SUM_W'(match_amt_q) + SUM_W'(merge_amt);
			end else if (free_q && action_hrs_q != 4'd0) begin
				sum_fin = sum_q + SUM_W'(amt_q);
			end
		end
	end
	assign sum_sat = (sum_fin > SUM_W'(iob_pkg::AMT_MAX)) ? iob_pkg::AMT_MAX : sum_fin[19:0];

	// suggestion: food plus signed correction minus on-board insulin
	assign sugg_total = $signed({5'd0, food_q})
		+ (corr_neg_q ? -$signed({4'd0, corr_q}) : $signed({4'd0, corr_q}))
		- $signed({4'd0, sum_sat});

	// one radix-16 divider step
	always_comb begin
		div_num_d = div_num_q;
		div_rem_d = div_rem_q;
		div_sh    = '0;
		for (int k = 0; k < 4; k++) begin
			div_sh    = {div_rem_d, div_num_d[iob_pkg::DivNumW-1]};
			div_num_d = {div_num_d[iob_pkg::DivNumW-2:0], 1'b0};
			if (div_sh >= {1'b0, div_den_q}) begin
				div_rem_d    = iob_pkg::DivDenW'(div_sh - {1'b0, div_den_q});
				div_num_d[0] = 1'b1;
			end else begin
				div_rem_d = div_sh[iob_pkg::DivDenW-1:0];
			end
		end
	end

	// table writes: clearing pass, freeing expired entries, final record
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		case (st_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_EV: begin
				if (e_valid && e_dead) begin
					ram_we = 1'b1;
				end
			end
			ST_FIN: begin
				if (!scan_only_q && match_q) begin
					ram_we    = 1'b1;
					ram_waddr = match_idx_q;
					ram_wdata = {1'b1, match_hrs_q, merge_amt, now_t};
				end else if (!scan_only_q && free_q) begin
					ram_we    = 1'b1;
					ram_waddr = free_idx_q;
					ram_wdata = {1'b1, action_hrs_q, 20'(amt_q), now_t};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	iob_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carb_ratio_q  <= 8'd10;
			corr_factor_q <= 9'd50;
			target_glu_q  <= 9'd110;
			action_hrs_q  <= 4'd5;
			basal_amt_q   <= 16'd0;
			ext_total_q   <= 15'd0;
			immed_pct_q   <= 7'd50;
			ext_hours_q   <= 4'd2;
			glu_q         <= '0;
			on_board_q    <= '0;
			phase_q       <= iob_pkg::PH_IDLE;
			tick_q        <= '0;
			hrs_done_q    <= '0;
			st_q          <= ST_CLR;
			ret_q         <= ST_IDLE;
			item_q        <= '0;
			idx_q         <= '0;
			sum_q         <= '0;
			amt_q         <= '0;
			lower_q       <= 1'b0;
			scan_only_q   <= 1'b0;
			match_q       <= 1'b0;
			match_idx_q   <= '0;
			match_amt_q   <= '0;
			match_hrs_q   <= '0;
			free_q        <= 1'b0;
			free_idx_q    <= '0;
			e_amt_q       <= '0;
			left_q        <= '0;
			span_q        <= '0;
			food_q        <= '0;
			corr_q        <= '0;
			corr_neg_q    <= 1'b0;
			delivered_q   <= '0;
			ovf_q         <= 1'b0;
			sugg_q        <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
			div_num_q     <= '0;
			div_den_q     <= '0;
			div_rem_q     <= '0;
			div_cnt_q     <= '0;
		end else begin
			// register writes, only while idle
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					iob_pkg::REG_CARB_RATIO:  carb_ratio_q  <= cfg_data[7:0];
					iob_pkg::REG_CORR_FACTOR: corr_factor_q <= cfg_data[8:0];
					iob_pkg::REG_TARGET_GLU:  target_glu_q  <= cfg_data[8:0];
					iob_pkg::REG_ACTION_HRS:  action_hrs_q  <= cfg_data[3:0];
					iob_pkg::REG_BASAL_AMT:   basal_amt_q   <= cfg_data;
					iob_pkg::REG_EXT_TOTAL:   ext_total_q   <= cfg_data[14:0];
					iob_pkg::REG_IMMED_PCT:   immed_pct_q   <= cfg_data[6:0];
					iob_pkg::REG_EXT_HOURS:   ext_hours_q   <= cfg_data[3:0];
					default: begin
					end
				endcase
			end

			// result taken downstream; in ST_OUT the new item takes its place
			if (rsp_valid_q && rsp_ready && st_q != ST_OUT) begin
				rsp_valid_q <= 1'b0;
			end

			case (st_q)
				// mark every entry free after reset
				ST_CLR: begin
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						st_q  <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						item_q <= req_item;
						st_q   <= ST_PRE;
					end
				end
				// decode the action and launch the first divide if any
				ST_PRE: begin
					sugg_q      <= '0;
					delivered_q <= '0;
					ovf_q       <= 1'b0;
					scan_only_q <= 1'b0;
					div_rem_q   <= '0;
					div_cnt_q   <= '0;
					case (item_q.action)
						iob_pkg::ACT_BOLUS: begin
							amt_q   <= 16'(item_q.dose_amount);
							lower_q <= 1'b1;
							st_q    <= ST_REC;
						end
						iob_pkg::ACT_BASAL: begin
							amt_q   <= basal_amt_q;
							lower_q <= 1'b0;
							st_q    <= ST_REC;
						end
						iob_pkg::ACT_SUGGEST: begin
							div_num_q <= 32'(item_q.carbs_grams * iob_pkg::MILLI);
							div_den_q <= 10'(ratio);
							ret_q     <= ST_SUG1;
							st_q      <= ST_DIV;
						end
						iob_pkg::ACT_EXT_START: begin
							if (phase_q == iob_pkg::PH_IDLE) begin
								phase_q    <= iob_pkg::PH_IMMED;
								tick_q     <= '0;
								hrs_done_q <= '0;
							end
							st_q <= ST_OUT;
						end
						iob_pkg::ACT_EXT_TICK: begin
							if (phase_q == iob_pkg::PH_IMMED) begin
								div_num_q <= 32'(ext_total_q * pct);
								div_den_q <= 10'(iob_pkg::PCT_FULL);
								ret_q     <= ST_IMM;
								st_q      <= ST_DIV;
							end else if (phase_q == iob_pkg::PH_SPREAD) begin
								if (tick_sum >= 7'(iob_pkg::MIN_PER_HOUR)) begin
									tick_q    <= '0;
									div_num_q <= 32'(ext_total_q * pct);
									div_den_q <= 10'(iob_pkg::PCT_FULL);
									ret_q     <= ST_HR1;
									st_q      <= ST_DIV;
								end else begin
									tick_q <= tick_sum[5:0];
									st_q   <= ST_OUT;
								end
							end else begin
								st_q <= ST_OUT;
							end
						end
						iob_pkg::ACT_LOAD_GLU: begin
							glu_q <= item_q.glucose_reading;
							st_q  <= ST_OUT;
						end
						default: begin
							st_q <= ST_OUT;
						end
					endcase
				end
				ST_DIV: begin
					div_num_q <= div_num_d;
					div_rem_q <= div_rem_d;
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_cnt_q == 3'd7) begin
						st_q <= ret_q;
					end
				end
				// food part done, now the correction part
				ST_SUG1: begin
					food_q    <= div_num_q[18:0];
					div_rem_q <= '0;
					div_cnt_q <= '0;
					if (item_q.glucose_reading >= 10'(target_glu_q)) begin
						corr_neg_q <= 1'b0;
						div_num_q  <= 32'((item_q.glucose_reading - 10'(target_glu_q))
							* iob_pkg::MILLI);
					end else begin
						corr_neg_q <= 1'b1;
						div_num_q  <= 32'((10'(target_glu_q) - item_q.glucose_reading)
							* iob_pkg::MILLI);
					end
					div_den_q <= 10'(cf);
					ret_q     <= ST_SUG2;
					st_q      <= ST_DIV;
				end
				ST_SUG2: begin
					corr_q      <= div_num_q[19:0];
					scan_only_q <= 1'b1;
					idx_q       <= '0;
					sum_q       <= '0;
					match_q     <= 1'b0;
					free_q      <= 1'b0;
					st_q        <= ST_RD;
				end
				// immediate part of an extended bolus
				ST_IMM: begin
					amt_q   <= 16'(div_num_q[14:0]);
					lower_q <= 1'b1;
					phase_q <= iob_pkg::PH_SPREAD;
					st_q    <= ST_REC;
				end
				// hourly portion: (total - immediate) / hours
				ST_HR1: begin
					div_num_q <= 32'(ext_total_q - div_num_q[14:0]);
					div_den_q <= 10'(ehr);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					ret_q     <= ST_HR2;
					st_q      <= ST_DIV;
				end
				ST_HR2: begin
					amt_q   <= 16'(div_num_q[14:0]);
					lower_q <= 1'b1;
					if (hrs_next >= ehr) begin
						phase_q    <= iob_pkg::PH_IDLE;
						hrs_done_q <= '0;
						tick_q     <= '0;
					end else begin
						hrs_done_q <= hrs_next;
					end
					st_q <= ST_REC;
				end
				// a zero amount leaves the table alone
				ST_REC: begin
					idx_q   <= '0;
					sum_q   <= '0;
					match_q <= 1'b0;
					free_q  <= 1'b0;
					st_q    <= (amt_q == 16'd0) ? ST_OUT : ST_RD;
				end
				ST_RD: begin
					st_q <= ST_EV;
				end
				// free expired entries, find the same-minute entry and a free slot
				ST_EV: begin
					if (!e_valid || e_dead) begin
						if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_q;
						end
						idx_q <= idx_q + 1'b1;
						st_q  <= (idx_q == LAST_IDX) ? ST_FIN : ST_RD;
					end else begin
						if (!match_q && e_time == now_t) begin
							match_q     <= 1'b1;
							match_idx_q <= idx_q;
							match_amt_q <= e_amt;
							match_hrs_q <= e_hours;
						end
						e_amt_q <= e_amt;
						span_q  <= e_span;
						left_q  <= 10'(e_span - 10'(dt));
						st_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					div_num_q <= 32'(e_amt_q * left_q);
					div_den_q <= span_q;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					ret_q     <= ST_ACC;
					st_q      <= ST_DIV;
				end
				ST_ACC: begin
					sum_q <= sum_q + SUM_W'(div_num_q[19:0]);
					idx_q <= idx_q + 1'b1;
					st_q  <= (idx_q == LAST_IDX) ? ST_FIN : ST_RD;
				end
				ST_FIN: begin
					on_board_q <= sum_sat;
					idx_q      <= '0;
					if (scan_only_q) begin
						if (sugg_total < 0) begin
							sugg_q <= '0;
						end else if (sugg_total > 24'sd65535) begin
							sugg_q <= 16'hFFFF;
						end else begin
							sugg_q <= sugg_total[15:0];
						end
						st_q <= ST_OUT;
					end else if (match_q || free_q) begin
						delivered_q <= amt_q;
						if (lower_q) begin
							div_num_q <= 32'(corr_factor_q * amt_q);
							div_den_q <= iob_pkg::MILLI;
							div_rem_q <= '0;
							div_cnt_q <= '0;
							ret_q     <= ST_GLU;
							st_q      <= ST_DIV;
						end else begin
							st_q <= ST_OUT;
						end
					end else begin
						ovf_q <= 1'b1;
						st_q  <= ST_OUT;
					end
				end
				// glucose drop floored at zero
				ST_GLU: begin
					if (div_num_q >= 32'(glu_q)) begin
						glu_q <= '0;
					end else begin
						glu_q <= glu_q - div_num_q[9:0];
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.suggested_bolus    <= sugg_q;
						rsp_q.insulin_on_board   <= on_board_q;
						rsp_q.glucose_estimate   <= glu_q;
						rsp_q.delivered_now      <= delivered_q;
						rsp_q.extended_phase_out <= phase_q;
						rsp_q.table_overflow     <= ovf_q;
						rsp_valid_q              <= 1'b1;
						st_q                     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("extended phase holds an unused code");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !ram_we)
		else $error("table written while idle");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (st_q == ST_PRE))
		else $error("accepted item not decoded");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && rsp_valid_q && !rsp_ready) |=> (st_q == ST_OUT))
		else $error("result overwrote a pending item");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (div_rem_q < div_den_q))
		else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/core/iob_ram.sv
// ----------------------------------------------------------------------------
// iob_ram: generic single-port-write ram with registered read
// One write and one read address per cycle, read data in the following cycle.
// ----------------------------------------------------------------------------
module iob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> bench/insulin_bolus_advisor_iob_tb.sv
// ----------------------------------------------------------------------------
// insulin_bolus_advisor_iob_tb: self-checking bench of the bolus advisor
// A queue-fed driver sends action items, a monitor predicts each result from
// its own copy of the delivery table and registers, and compares field by
// field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module insulin_bolus_advisor_iob_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int TICK_MIN    = 5;
	localparam longint unsigned TMASK = 64'hFFFFF;
	localparam longint unsigned SAT20 = 64'hFFFFF;
	localparam int LATENCY     = 12 * DEPTH + 45;
	localparam int STALL_LIMIT = 40 * LATENCY;

	typedef struct {
		logic [iob_pkg::CfgIdxW-1:0] idx;
		logic [iob_pkg::CfgDatW-1:0] dat;
	} reg_write_t;

	localparam logic [iob_pkg::CfgIdxW-1:0] REG_ORDER [8] = '{iob_pkg::REG_CARB_RATIO,
		iob_pkg::REG_CORR_FACTOR, iob_pkg::REG_TARGET_GLU, iob_pkg::REG_ACTION_HRS,
		iob_pkg::REG_BASAL_AMT, iob_pkg::REG_EXT_TOTAL, iob_pkg::REG_IMMED_PCT,
		iob_pkg::REG_EXT_HOURS};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	iob_pkg::req_item_t req_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	iob_pkg::rsp_item_t rsp_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [iob_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [iob_pkg::CfgDatW-1:0] cfg_data = '0;

	insulin_bolus_advisor_iob u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	// shadow delivery table
	longint unsigned dose_time [DEPTH];
	longint unsigned dose_amt [DEPTH];
	longint unsigned dose_hrs [DEPTH];
	bit              dose_live [DEPTH];
	longint unsigned glu_est, iob_sum, ext_phase, ext_minutes, ext_hours_done;
	// shadow registers, reset values
	longint unsigned r_ratio = 10, r_cf = 50, r_target = 110, r_act_hrs = 5;
	longint unsigned r_basal = 0, r_ext_total = 0, r_pct = 50, r_ext_hrs = 2;

	iob_pkg::rsp_item_t advice_due [$];
	iob_pkg::req_item_t action_q [$];
	reg_write_t reg_q [$];

	// sum of linearly decaying remainders, frees expired entries
	function automatic void sum_on_board(longint unsigned now);
		longint unsigned s, dt, span;
		s = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!dose_live[i]) continue;
			dt = (now - dose_time[i]) & TMASK;
			span = dose_hrs[i] * 60;
			if (dose_amt[i] == 0 || dt >= span) begin
				dose_live[i] = 1'b0;
				continue;
			end
			s += dose_amt[i] * (span - dt) / span;
			if (s > SAT20) s = SAT20;
		end
		iob_sum = s;
	endfunction

	// records a delivery, merging same-minute entries; returns amount recorded
	function automatic longint unsigned log_dose(longint unsigned now, longint unsigned amt,
			inout bit dropped);
		int slot;
		longint unsigned s;
		slot = -1;
		if (amt == 0) return 0;
		sum_on_board(now);
		for (int i = 0; i < DEPTH; i++) begin
			if (dose_live[i] && dose_time[i] == now) begin
				s = dose_amt[i] + amt;
				dose_amt[i] = s > SAT20 ? SAT20 : s;
				sum_on_board(now);
				return amt;
			end
			if (!dose_live[i] && slot < 0) slot = i;
		end
		if (slot < 0) begin
			dropped = 1'b1;
			return 0;
		end
		dose_live[slot] = 1'b1;
		dose_time[slot] = now;
		dose_amt[slot] = amt > SAT20 ? SAT20 : amt;
		dose_hrs[slot] = r_act_hrs & 15;
		sum_on_board(now);
		return amt;
	endfunction

	function automatic void drop_glucose(longint unsigned amt);
		longint unsigned d;
		d = r_cf * amt / 1000;
		glu_est = d >= glu_est ? 0 : glu_est - d;
	endfunction

	function automatic iob_pkg::rsp_item_t advise_step(iob_pkg::req_item_t it);
		iob_pkg::rsp_item_t r;
		longint unsigned now, pct, ehrs, immed, given, sugg, ratio, cf, t;
		longint food, corr, total;
		bit dropped;
		now = 64'(it.now_minutes);
		given = 0;
		sugg = 0;
		dropped = 1'b0;
		pct = r_pct > 100 ? 100 : r_pct;
		ehrs = r_ext_hrs == 0 ? 1 : r_ext_hrs;
		immed = r_ext_total * pct / 100;
		case (it.action)
			iob_pkg::ACT_BOLUS: begin
				given = log_dose(now, 64'(it.dose_amount), dropped);
				drop_glucose(given);
			end
			iob_pkg::ACT_BASAL: given = log_dose(now, r_basal, dropped);
			iob_pkg::ACT_SUGGEST: begin
				ratio = r_ratio == 0 ? 1 : r_ratio;
				cf = r_cf == 0 ? 1 : r_cf;
				food = longint'(64'(it.carbs_grams) * 1000 / ratio);
				if (it.glucose_reading >= r_target)
					corr = longint'((it.glucose_reading - r_target) * 1000 / cf);
				else
					corr = -longint'((r_target - it.glucose_reading) * 1000 / cf);
				sum_on_board(now);
				total = food + corr - longint'(iob_sum);
				if (total < 0) total = 0;
				if (total > 65535) total = 65535;
				sugg = total;
			end
			iob_pkg::ACT_EXT_START: begin
				if (ext_phase == iob_pkg::PH_IDLE) begin
					ext_phase = 64'(iob_pkg::PH_IMMED);
					ext_minutes = 0;
					ext_hours_done = 0;
				end
			end
			iob_pkg::ACT_EXT_TICK: begin
				if (ext_phase == iob_pkg::PH_IMMED) begin
					given = log_dose(now, immed, dropped);
					drop_glucose(given);
					ext_phase = 64'(iob_pkg::PH_SPREAD);
				end else if (ext_phase == iob_pkg::PH_SPREAD) begin
					t = ext_minutes + TICK_MIN;
					if (t >= 60) begin
						ext_minutes = 0;
						ext_hours_done = (ext_hours_done + 1) & 15;
						given = log_dose(now, (r_ext_total - immed) / ehrs, dropped);
						drop_glucose(given);
						if (ext_hours_done >= ehrs) begin
							ext_phase = 64'(iob_pkg::PH_IDLE);
							ext_hours_done = 0;
							ext_minutes = 0;
						end
					end else begin
						ext_minutes = t;
					end
				end
			end
			iob_pkg::ACT_LOAD_GLU: glu_est = 64'(it.glucose_reading);
			default: ;
		endcase
		r.suggested_bolus = 16'(sugg);
		r.insulin_on_board = 20'(iob_sum);
		r.glucose_estimate = 10'(glu_est);
		r.delivered_now = given > 65535 ? 16'hFFFF : 16'(given);
		r.extended_phase_out = 2'(ext_phase);
		r.table_overflow = dropped;
		return r;
	endfunction

	function automatic void set_reg(logic [iob_pkg::CfgIdxW-1:0] idx,
			logic [iob_pkg::CfgDatW-1:0] v);
		case (idx)
			iob_pkg::REG_CARB_RATIO:  r_ratio = 64'(v[7:0]);
			iob_pkg::REG_CORR_FACTOR: r_cf = 64'(v[8:0]);
			iob_pkg::REG_TARGET_GLU:  r_target = 64'(v[8:0]);
			iob_pkg::REG_ACTION_HRS:  r_act_hrs = 64'(v[3:0]);
			iob_pkg::REG_BASAL_AMT:   r_basal = 64'(v);
			iob_pkg::REG_EXT_TOTAL:   r_ext_total = 64'(v[14:0]);
			iob_pkg::REG_IMMED_PCT:   r_pct = 64'(v[6:0]);
			iob_pkg::REG_EXT_HOURS:   r_ext_hrs = 64'(v[3:0]);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------ drive / monitor
	int send_idle = 0, recv_idle = 0;
	bit req_took = 1'b0, cfg_took = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;

	task automatic flag(string fname, longint unsigned e, longint unsigned a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %0d, got %0d", fname, $realtime, e, a);
	endtask

	// inputs move on the falling edge only
	always @(negedge clk) begin
		if (arst_n) begin
			rsp_ready <= $urandom_range(99) >= recv_idle;
			if (!req_valid || req_took) begin
				if (action_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					req_item <= action_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			if (!cfg_valid || cfg_took) begin
				if (reg_q.size() > 0) begin
					cfg_index <= reg_q[0].idx;
					cfg_data <= reg_q[0].dat;
					void'(reg_q.pop_front());
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// handshakes are sampled on the rising edge
	always @(posedge clk) begin
		iob_pkg::rsp_item_t want;
		req_took = arst_n && req_valid && req_ready;
		cfg_took = arst_n && cfg_valid && cfg_ready;
		if (cfg_took) set_reg(cfg_index, cfg_data);
		if (req_took) advice_due.push_back(advise_step(req_item));
		if (arst_n && rsp_valid && rsp_ready) begin
			if (advice_due.size() == 0) begin
				flag("unexpected item", 0, 1);
			end else begin
				want = advice_due.pop_front();
				if (rsp_item.suggested_bolus !== want.suggested_bolus)
					flag("suggested_bolus", want.suggested_bolus, rsp_item.suggested_bolus);
				if (rsp_item.insulin_on_board !== want.insulin_on_board)
					flag("insulin_on_board", want.insulin_on_board, rsp_item.insulin_on_board);
				if (rsp_item.glucose_estimate !== want.glucose_estimate)
					flag("glucose_estimate", want.glucose_estimate, rsp_item.glucose_estimate);
				if (rsp_item.delivered_now !== want.delivered_now)
					flag("delivered_now", want.delivered_now, rsp_item.delivered_now);
				if (rsp_item.extended_phase_out !== want.extended_phase_out)
					flag("extended_phase_out", want.extended_phase_out,
						rsp_item.extended_phase_out);
				if (rsp_item.table_overflow !== want.table_overflow)
					flag("table_overflow", want.table_overflow, rsp_item.table_overflow);
			end
		end
		// watchdog on cycles with no handshake at all
		if (req_took || cfg_took || (rsp_valid && rsp_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("insulin_bolus_advisor_iob_tb: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	longint unsigned clock_min = 0;

	function automatic void push_act(logic [2:0] act, longint unsigned dt,
			logic [14:0] dose, logic [8:0] carbs, logic [9:0] glu);
		iob_pkg::req_item_t it;
		clock_min = (clock_min + dt) & TMASK;
		it.action = act;
		it.now_minutes = 20'(clock_min);
		it.dose_amount = dose;
		it.carbs_grams = carbs;
		it.glucose_reading = glu;
		action_q.push_back(it);
	endfunction

	function automatic void push_random();
		int pick;
		longint unsigned dt;
		logic [14:0] dose;
		pick = $urandom_range(99);
		case ($urandom_range(19))
			0, 1, 2, 3:  dt = 0;
			4, 5, 6:     dt = 64'($urandom_range(1, 120));
			7:           dt = 64'($urandom_range(0, 1048575));
			default:     dt = TICK_MIN;
		endcase
		case ($urandom_range(9))
			0:       dose = 15'h7FFF;
			1:       dose = 0;
			default: dose = 15'($urandom_range(0, 25000));
		endcase
		if (pick < 25)
			push_act(iob_pkg::ACT_BOLUS, dt, dose, 9'($urandom), 10'($urandom));
		else if (pick < 35)
			push_act(iob_pkg::ACT_BASAL, dt, dose, 9'($urandom), 10'($urandom));
		else if (pick < 55)
			push_act(iob_pkg::ACT_SUGGEST, dt, dose, 9'($urandom), 10'($urandom));
		else if (pick < 60) begin
			// extended bolus start followed by a run of ticks
			push_act(iob_pkg::ACT_EXT_START, dt, dose, 9'($urandom), 10'($urandom));
			repeat ($urandom_range(13, 40))
				push_act(iob_pkg::ACT_EXT_TICK, TICK_MIN, 15'($urandom), 9'($urandom),
					10'($urandom));
		end else if (pick < 85)
			push_act(iob_pkg::ACT_EXT_TICK, dt, dose, 9'($urandom), 10'($urandom));
		else if (pick < 95)
			push_act(iob_pkg::ACT_LOAD_GLU, dt, dose, 9'($urandom), 10'($urandom));
		else
			push_act(3'($urandom_range(6, 7)), dt, dose, 9'($urandom), 10'($urandom));
	endfunction

	task automatic load_regs(input int v [8]);
		reg_write_t w;
		for (int i = 0; i < 8; i++) begin
			w.idx = REG_ORDER[i];
			w.dat = 16'(v[i]);
			reg_q.push_back(w);
		end
		while (reg_q.size() > 0 || cfg_valid) @(posedge clk);
	endtask

	// sender holds off until every result has come, then waits out the block
	task automatic drain();
		while (action_q.size() > 0 || req_valid || advice_due.size() > 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		int regs [8];
		for (int i = 0; i < DEPTH; i++) dose_live[i] = 1'b0;
		glu_est = 0;
		iob_sum = 0;
		ext_phase = 64'(iob_pkg::PH_IDLE);
		ext_minutes = 0;
		ext_hours_done = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			// sender idles lightly, then receiver, then neither
			send_idle = ph < 3 ? 8 : (ph < 6 ? 49 : 0);
			recv_idle = ph < 3 ? 49 : (ph < 6 ? 8 : 0);
			case (ph)
				0: ; // reset values for the directed part
				1: regs = '{0, 0, 0, 0, 0, 0, 0, 0};                    // zero divisors
				2: regs = '{255, 511, 511, 15, 65535, 32767, 127, 15};  // full fields
				3: regs = '{1, 1, 60, 1, 0, 0, 0, 1};                   // low ends
				4: regs = '{150, 400, 300, 12, 35000, 25000, 100, 8};   // high ends
				default: regs = '{$urandom_range(1, 150), $urandom_range(1, 400),
					$urandom_range(60, 300), $urandom_range(1, 12),
					$urandom_range(0, 35000), $urandom_range(0, 25000),
					$urandom_range(0, 100), $urandom_range(1, 8)};
			endcase
			if (ph > 0) load_regs(regs);

			if (ph == 0) begin
				push_act(iob_pkg::ACT_SUGGEST, 0, 0, 0, 0);
				push_act(iob_pkg::ACT_SUGGEST, 0, 0, 9'h1FF, 10'h3FF);
				push_act(iob_pkg::ACT_LOAD_GLU, 0, 0, 0, 10'h3FF);
				push_act(iob_pkg::ACT_BOLUS, 1, 0, 0, 0);            // zero amount
				push_act(iob_pkg::ACT_BOLUS, 0, 15'h7FFF, 0, 0);
				push_act(iob_pkg::ACT_BOLUS, 0, 1000, 0, 0);         // same-minute merge
				push_act(iob_pkg::ACT_BASAL, 3, 0, 0, 0);
				push_act(iob_pkg::ACT_SUGGEST, 7, 0, 250, 400);
				push_act(iob_pkg::ACT_EXT_TICK, 5, 0, 0, 0);         // tick while idle
				push_act(iob_pkg::ACT_EXT_START, 0, 0, 0, 0);
				push_act(iob_pkg::ACT_EXT_START, 0, 0, 0, 0);        // start while active
				repeat (26) push_act(iob_pkg::ACT_EXT_TICK, TICK_MIN, 0, 0, 0);
				push_act(3'd6, 0, 15'h7FFF, 9'h1FF, 10'h3FF);
				push_act(3'd7, 0, 0, 0, 0);
				clock_min = 20'hFFFFE;
				push_act(iob_pkg::ACT_BOLUS, 1, 2000, 0, 0);
				push_act(iob_pkg::ACT_SUGGEST, 6, 0, 30, 90);        // time wraps past zero
			end
			if (ph == 4) begin
				// same-minute pile-up past the amount ceiling, then a full table
				repeat (34) push_act(iob_pkg::ACT_BOLUS, 0, 15'h7FFF, 0, 0);
				repeat (67) push_act(iob_pkg::ACT_BOLUS, 1, 15'($urandom_range(1, 25000)), 0, 0);
				push_act(iob_pkg::ACT_BASAL, 1, 0, 0, 0);
			end
			repeat (ph == 4 ? 10 : 48) push_random();
			drain();
		end

		if (mismatches == 0 && advice_due.size() == 0) begin
			$display("insulin_bolus_advisor_iob_tb: PASS");
		end else begin
			$display("insulin_bolus_advisor_iob_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> insulin_bolus_advisor_iob.f
rtl/core/iob_pkg.sv
rtl/core/iob_ram.sv
rtl/core/insulin_bolus_advisor_iob.sv
bench/insulin_bolus_advisor_iob_tb.sv
